// ===== rtl/holt_pkg.sv =====
package holt_pkg;

  localparam int unsigned ObsW    = 24;
  localparam int unsigned StW     = 40;
  localparam int unsigned AheadW  = 32;
  localparam int unsigned GainW   = 17;
  localparam int unsigned HorW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned WideW   = 48;
  localparam int unsigned OprW    = 42;
  localparam int unsigned ChunkW  = 21;
  localparam int unsigned MulAW   = 18;
  localparam int unsigned MulBW   = ChunkW + 1;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AccW    = 60;

  localparam logic [GainW-1:0] GainOne       = 17'd65536;
  localparam logic [GainW-1:0] LevelGainRst  = 17'd32768;
  localparam logic [GainW-1:0] TrendGainRst  = 17'd19661;
  localparam logic [HorW-1:0]  HorizonRst    = 8'd1;

  localparam logic [CfgIdxW-1:0] CfgLevelGain = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTrendGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHorizon   = 2'd2;

  // saturate a wide sum to the 40-bit state format
  function automatic logic signed [StW-1:0] sat_st(input logic signed [WideW-1:0] v);
    logic signed [StW-1:0] r;
    if (v > 48'sh007F_FFFF_FFFF) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < 48'shFF80_0000_0000) begin
      r = 40'sh80_0000_0000;
    end else begin
      r = v[StW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ObsW-1:0] sat_fc(input logic signed [StW:0] v);
    logic signed [ObsW-1:0] r;
    if (v > 41'sd8388607) begin
      r = 24'sh7F_FFFF;
    end else if (v < -41'sd8388608) begin
      r = 24'sh80_0000;
    end else begin
      r = v[ObsW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [AheadW-1:0] sat_ah(input logic signed [StW-1:0] v);
    logic signed [AheadW-1:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[AheadW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/holt_trend_forecaster.sv =====
// Holt linear trend forecaster, fixed point.
// Input channel: observation_i (signed Q16.8) with in_valid_i / in_stall_o.
//   A request is taken on a clock edge with in_valid_i high and in_stall_o
//   low. in_stall_o is low only while the sequencer is idle.
// Output channel: forecast_o, ahead_forecast_o, ready_res_o with
//   out_valid_o / out_stall_i, one result per request, held in an output
//   register until taken.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects level gain,
//   trend gain or horizon; other indexes are dropped. Always ready.
// After acceptance the first sample goes straight to the final step; the
//   second seeds level and trend, then runs only the horizon product.
// No new request is taken before the last result leaves the final step.
// One 18x22 signed multiplier is reused for three products (alpha, beta,
//   horizon), each split into a low and a high 21-bit chunk, and the sequencer walks these in turn.
// Reset (rst_ni low, async): gains and horizon return to defaults, warm-up
//   restarts, the output register empties.
// Receiver stall: the finished result waits in the final step until the
//   output register frees up; no new request is taken meanwhile.
module holt_trend_forecaster import holt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ObsW-1:0]   observation_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [ObsW-1:0]   forecast_o,
  output logic signed [AheadW-1:0] ahead_forecast_o,
  output logic                     ready_res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [GainW-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_MLO, S_MHI, S_LVL, S_TRD, S_DONE
  } state_e;

  typedef enum logic [1:0] {PH_EMPTY, PH_ONE, PH_READY} phase_e;
  typedef enum logic [1:0] {PASS_LVL, PASS_TRD, PASS_AHD} pass_e;

  state_e state_q;
  phase_e phase_q;
  pass_e  pass_q;

  logic [GainW-1:0] level_gain_q, trend_gain_q;
  logic [HorW-1:0]  horizon_q;

  logic signed [StW-1:0]   level_q, trend_q, sum_q;
  logic signed [ObsW-1:0]  obs_q, first_q, fc_q;
  logic signed [OprW-1:0]  opr_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [MulAW-1:0] gain_q;
  logic                    ready_q, zero_q;

  logic                    out_valid_q;
  logic signed [ObsW-1:0]  out_fc_q;
  logic signed [AheadW-1:0] out_ahead_q;
  logic                    out_ready_q;

  logic accept, out_free;
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // clip gains above one
  logic [GainW-1:0] a_clip, b_clip;
  assign a_clip = (level_gain_q > GainOne) ? GainOne : level_gain_q;
  assign b_clip = (trend_gain_q > GainOne) ? GainOne : trend_gain_q;

  // second sample: seed level and trend
  logic signed [ObsW:0]  init_diff;
  logic signed [StW-1:0] level_init, trend_init;
  assign init_diff  = (ObsW+1)'(observation_i) - (ObsW+1)'(first_q);
  assign level_init = StW'($signed({first_q, 8'd0}));
  assign trend_init = StW'($signed({init_diff, 8'd0}));

  // one-step forecast and alpha operand
  logic signed [StW-1:0] sum_sat;
  logic signed [StW:0]   fc_tmp, diff;
  logic signed [31:0]    obs_scaled;
  assign sum_sat    = sat_st(WideW'(level_q) + WideW'(trend_q));
  assign fc_tmp     = ((StW+1)'(sum_sat) + 41'sd128) >>> 8;
  assign obs_scaled = $signed({obs_q, 8'd0});
  assign diff       = (StW+1)'(obs_scaled) - (StW+1)'(sum_sat);

  // shared multiplier, low chunk unsigned, high chunk signed
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  assign mul_b = (state_q == S_MLO) ? $signed({1'b0, opr_q[ChunkW-1:0]})
                                    : $signed({opr_q[OprW-1], opr_q[OprW-1:ChunkW]});
  assign prod  = gain_q * mul_b;

  // round half up by 2^16
  logic signed [AccW-1:0]    acc_rnd;
  logic signed [AccW-17:0]   rnd16;
  assign acc_rnd = (acc_q + 60'sd32768) >>> 16;
  assign rnd16   = acc_rnd[AccW-17:0];

  logic signed [StW-1:0]  nl, nt;
  logic signed [OprW-1:0] err;
  assign nl  = sat_st(WideW'(sum_q) + WideW'(rnd16));
  assign err = OprW'(nl) - OprW'(level_q) - OprW'(trend_q);
  assign nt  = sat_st(WideW'(trend_q) + WideW'(rnd16));

  // ahead forecast: level + horizon*trend, round to Q.8
  logic signed [WideW-1:0]  ah_wide, ah_sh;
  logic signed [AheadW-1:0] ahead;
  assign ah_wide = WideW'(level_q) + $signed(acc_q[WideW-1:0]) + 48'sd128;
  assign ah_sh   = ah_wide >>> 8;
  assign ahead   = zero_q ? '0 : sat_ah(ah_sh[StW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_EMPTY;
      pass_q       <= PASS_LVL;
      level_gain_q <= LevelGainRst;
      trend_gain_q <= TrendGainRst;
      horizon_q    <= HorizonRst;
      level_q      <= '0;
      trend_q      <= '0;
      sum_q        <= '0;
      obs_q        <= '0;
      first_q      <= '0;
      fc_q         <= '0;
      opr_q        <= '0;
      acc_q        <= '0;
      gain_q       <= '0;
      ready_q      <= 1'b0;
      zero_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_fc_q     <= '0;
      out_ahead_q  <= '0;
      out_ready_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgLevelGain: level_gain_q <= cfg_data_i;
          CfgTrendGain: trend_gain_q <= cfg_data_i;
          CfgHorizon:   horizon_q    <= cfg_data_i[HorW-1:0];
          default: ;
        endcase
      end

      // drop the result once taken; the final step reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            obs_q <= observation_i;
            unique case (phase_q)
              PH_EMPTY: begin
                first_q <= observation_i;
                fc_q    <= observation_i;
                ready_q <= 1'b0;
                zero_q  <= 1'b1;
                phase_q <= PH_ONE;
                state_q <= S_DONE;
              end
              PH_ONE: begin
                level_q <= level_init;
                trend_q <= trend_init;
                opr_q   <= OprW'(trend_init);
                gain_q  <= MulAW'(horizon_q);
                fc_q    <= observation_i;
                ready_q <= 1'b1;
                zero_q  <= 1'b0;
                pass_q  <= PASS_AHD;
                phase_q <= PH_READY;
                state_q <= S_MLO;
              end
              default: begin
                ready_q <= 1'b1;
                zero_q  <= 1'b0;
                state_q <= S_SUM;
              end
            endcase
          end
        end
        S_SUM: begin
          sum_q   <= sum_sat;
          fc_q    <= sat_fc(fc_tmp);
          opr_q   <= OprW'(diff);
          gain_q  <= MulAW'(a_clip);
          pass_q  <= PASS_LVL;
          state_q <= S_MLO;
        end
        S_MLO: begin
          acc_q   <= AccW'(prod);
          state_q <= S_MHI;
        end
        S_MHI: begin
          acc_q <= acc_q + (AccW'(prod) <<< ChunkW);
          unique case (pass_q)
            PASS_LVL: state_q <= S_LVL;
            PASS_TRD: state_q <= S_TRD;
            default:  state_q <= S_DONE;
          endcase
        end
        S_LVL: begin
          level_q <= nl;
          opr_q   <= err;
          gain_q  <= MulAW'(b_clip);
          pass_q  <= PASS_TRD;
          state_q <= S_MLO;
        end
        S_TRD: begin
          trend_q <= nt;
          opr_q   <= OprW'(nt);
          gain_q  <= MulAW'(horizon_q);
          pass_q  <= PASS_AHD;
          state_q <= S_MLO;
        end
        S_DONE: begin
          // hold until the output register frees up
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_fc_q    <= fc_q;
            out_ahead_q <= ahead;
            out_ready_q <= ready_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign forecast_o       = out_fc_q;
  assign ahead_forecast_o = out_ahead_q;
  assign ready_res_o      = out_ready_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the final step");

  a_track_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (phase_q == PH_READY)) |=> (state_q == S_SUM))
    else $error("tracking sample skipped the sum step");

  a_ahead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ready_res_o) |-> (ahead_forecast_o == '0))
    else $error("ahead forecast nonzero before warm-up");

  a_mhi_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MHI) |=> (state_q == S_LVL || state_q == S_TRD || state_q == S_DONE))
    else $error("multiply pass left to a wrong step");

endmodule
